// ----- src/csbs_pkg.sv -----
// Shared types and codes for the checksummed register bus slave.
// Used by csbs_parser and checksummed_register_bus_slave_top; depends on nothing.

package csbs_pkg;

  // Input command selector carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_BUS  = 2'd0,
    CMD_HWR  = 2'd1,
    CMD_HRD  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Result kind carried on out_tuser.
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_HOST  = 1'b1;

  // Order of the reply header tokens.
  localparam logic [1:0] HT_ID  = 2'd0;
  localparam logic [1:0] HT_RC  = 2'd1;
  localparam logic [1:0] HT_LEN = 2'd2;
  localparam logic [1:0] HT_ROW = 2'd3;

  // Position inside an incoming frame.
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_ADDR = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_t;

  // Reply sequencer states.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HRD   = 7'b0000100,
    S_HDR   = 7'b0001000,
    S_WRD   = 7'b0010000,
    S_WDAT  = 7'b0100000,
    S_SUM   = 7'b1000000
  } seq_t;

  // Frame completion status from the parser, valid in the cycle of the sum token.
  typedef struct packed {
    logic hit;       // id and sum matched: a reply follows
    logic is_write;  // frame type equals the write code
  } fin_t;

endpackage

// ----- src/csbs_parser.sv -----
// Frame parser: header registers, running sum and the staging memory for data words.
// Depends on csbs_pkg.

module csbs_parser #(
  parameter int ENTRIES = 16,
  parameter int WORDS   = 16,
  localparam int LW = $clog2(WORDS + 1),
  localparam int SW = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int RW = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_en,
  input  logic             tok_start,
  input  logic [31:0]      tok_value,
  input  logic [7:0]       node_id,
  input  logic [7:0]       write_code,
  input  logic [SW-1:0]    stg_raddr,
  output logic [31:0]      stg_rdata,
  output logic [31:0]      hdr_id,
  output logic [LW-1:0]    hdr_len,
  output logic [RW-1:0]    hdr_row,
  output csbs_pkg::fin_t   fin
);

  csbs_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [31:0]   type_r, type_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [LW-1:0] seen_r, seen_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic          stg_we;
  logic [31:0]   stg_mem [WORDS];
  logic [31:0]   stg_rdata_r;
  logic [LW-1:0] len_cl;
  logic [RW-1:0] row_cl;

  // Signed clamp of the length token to 1..WORDS.
  always_comb begin
    if (tok_value[31] || tok_value == 32'd0) begin
      len_cl = LW'(1);
    end else if (tok_value > 32'(WORDS)) begin
      len_cl = LW'(WORDS);
    end else begin
      len_cl = tok_value[LW-1:0];
    end
  end

  // Signed clamp of the address token to 0..ENTRIES-1.
  always_comb begin
    if (tok_value[31]) begin
      row_cl = '0;
    end else if (tok_value > 32'(ENTRIES - 1)) begin
      row_cl = RW'(ENTRIES - 1);
    end else begin
      row_cl = tok_value[RW-1:0];
    end
  end

  // Frame phase sequencing and running sum.
  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    row_nxt      = row_r;
    seen_nxt     = seen_r;
    sum_nxt      = sum_r;
    stg_we       = 1'b0;
    fin.hit      = 1'b0;
    fin.is_write = (type_r == {24'd0, write_code});
    if (tok_en) begin
      if (tok_start) begin
        id_nxt    = tok_value;
        sum_nxt   = tok_value;
        phase_nxt = csbs_pkg::PH_TYPE;
      end else begin
        unique case (phase_r)
          csbs_pkg::PH_IDLE: begin
            phase_nxt = csbs_pkg::PH_IDLE;
          end
          csbs_pkg::PH_TYPE: begin
            type_nxt  = tok_value;
            sum_nxt   = sum_r + tok_value;
            phase_nxt = csbs_pkg::PH_LEN;
          end
          csbs_pkg::PH_LEN: begin
            len_nxt   = len_cl;
            sum_nxt   = sum_r + 32'(len_cl);
            phase_nxt = csbs_pkg::PH_ADDR;
          end
          csbs_pkg::PH_ADDR: begin
            row_nxt   = row_cl;
            sum_nxt   = sum_r + tok_value;
            seen_nxt  = '0;
            phase_nxt = csbs_pkg::PH_DATA;
          end
          csbs_pkg::PH_DATA: begin
            stg_we   = 1'b1;
            sum_nxt  = sum_r + tok_value;
            seen_nxt = seen_r + LW'(1);
            if (seen_nxt >= len_r) begin
              phase_nxt = csbs_pkg::PH_SUM;
            end
          end
          csbs_pkg::PH_SUM: begin
            fin.hit   = (id_r == {24'd0, node_id}) && (sum_r == tok_value);
            phase_nxt = csbs_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt = csbs_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csbs_pkg::PH_IDLE;
      id_r    <= '0;
      type_r  <= '0;
      len_r   <= '0;
      row_r   <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      row_r   <= row_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Staging memory: data words of the open frame, read back during a reply.
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[seen_r[SW-1:0]] <= tok_value;
    end
    stg_rdata_r <= stg_mem[stg_raddr];
  end

  assign stg_rdata = stg_rdata_r;
  assign hdr_id    = id_r;
  assign hdr_len   = len_r;
  assign hdr_row   = row_r;

endmodule

// ----- src/checksummed_register_bus_slave_top.sv -----
// Top level of the checksummed register bus slave: buffer memory, reply sequencer
// and output register. Depends on csbs_pkg and csbs_parser.
//
// Usage:
// The input channel (in_*) carries parsed bus tokens and host commands; in_tuser
// selects bus token, host word write or host word read. The output channel (out_*)
// carries reply frame tokens (out_tuser low) and host read data (out_tuser high);
// out_tlast marks the final result of one input transfer.
// A host read first registers the buffer word, then loads it into the output register
// in S_HRD. In a reply the word loop passes through S_WRD, which fetches the buffer
// word, and S_WDAT, which loads the word into the output register, for every word
// because the buffer memory has a registered read port, and the block takes no input
// until the whole reply has been loaded into the output register.
// A result waiting in the output register does not block the next input transfer
// in the idle state; a stalled receiver holds the reply sequencer where it stands.
// After reset the buffer memory is swept to zero, one word per cycle; in_tready stays
// low during that sweep while configuration writes are taken as usual. Configuration
// registers reset to node_id 0, write_code 1 and return_code 3.

module checksummed_register_bus_slave_top #(
  parameter int ENTRIES = 16,
  parameter int WORDS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // frame_start[0], value[32:1], entry[36:33], word[40:37]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // reply_first[0], value_res[32:1], last_entry[36:33]
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int DEPTH = ENTRIES * WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(WORDS + 1);
  localparam int SW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RW    = $clog2(ENTRIES);

  localparam logic [1:0] REG_NODE_ID = 2'd0;
  localparam logic [1:0] REG_WCODE   = 2'd1;
  localparam logic [1:0] REG_RCODE   = 2'd2;

  // Input fields.
  logic          in_start;
  logic [31:0]   in_value;
  logic [3:0]    in_entry;
  logic [3:0]    in_word;
  csbs_pkg::cmd_t in_cmd;
  logic          in_acc;

  assign in_start = in_tdata[0];
  assign in_value = in_tdata[32:1];
  assign in_entry = in_tdata[36:33];
  assign in_word  = in_tdata[40:37];
  assign in_cmd   = csbs_pkg::cmd_t'(in_tuser);

  // Configuration registers.
  logic [7:0] node_id_r, write_code_r, return_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r     <= 8'd0;
      write_code_r  <= 8'd1;
      return_code_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ID: node_id_r     <= cfg_wdata;
        REG_WCODE:   write_code_r  <= cfg_wdata;
        REG_RCODE:   return_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and reply registers.
  csbs_pkg::seq_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    hcnt_r, hcnt_nxt;
  logic [LW-1:0] wcnt_r, wcnt_nxt;
  logic [31:0]   rsum_r, rsum_nxt;
  logic          is_write_r, is_write_nxt;
  logic [RW-1:0] last_row_r, last_row_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic        ofirst_r, ofirst_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic        olast_r, olast_nxt;
  logic [3:0]  oent_r, oent_nxt;
  logic        slot_free;

  // Parser link.
  logic [31:0]    p_id;
  logic [LW-1:0]  p_len;
  logic [RW-1:0]  p_row;
  logic [31:0]    stg_rdata;
  csbs_pkg::fin_t fin;
  logic           tok_en;

  // Buffer memory ports.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   buf_mem [DEPTH];
  logic [31:0]   buf_rdata_r;

  // Host index and reply address, clamped to the buffer geometry.
  logic [31:0]   h_ent, h_wrd;
  logic [AW-1:0] h_idx, r_idx;
  logic [31:0]   hval, wval;

  assign h_ent = (32'(in_entry) > 32'(ENTRIES - 1)) ? 32'(ENTRIES - 1) : 32'(in_entry);
  assign h_wrd = (32'(in_word) > 32'(WORDS - 1)) ? 32'(WORDS - 1) : 32'(in_word);
  assign h_idx = AW'(h_ent * WORDS + h_wrd);
  assign r_idx = AW'(32'(p_row) * WORDS + 32'(wcnt_r));

  assign in_tready = (st_r == csbs_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tok_en    = in_acc && (in_cmd == csbs_pkg::CMD_BUS);
  assign slot_free = !ov_r || out_tready;

  csbs_parser #(
    .ENTRIES (ENTRIES),
    .WORDS   (WORDS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_en     (tok_en),
    .tok_start  (in_start),
    .tok_value  (in_value),
    .node_id    (node_id_r),
    .write_code (write_code_r),
    .stg_raddr  (wcnt_r[SW-1:0]),
    .stg_rdata  (stg_rdata),
    .hdr_id     (p_id),
    .hdr_len    (p_len),
    .hdr_row    (p_row),
    .fin        (fin)
  );

  // Header token values in reply order.
  always_comb begin
    unique case (hcnt_r)
      csbs_pkg::HT_ID:  hval = p_id;
      csbs_pkg::HT_RC:  hval = {24'd0, return_code_r};
      csbs_pkg::HT_LEN: hval = 32'(p_len);
      csbs_pkg::HT_ROW: hval = 32'(p_row);
      default:          hval = p_id;
    endcase
  end

  // A write frame replies with the staged words it stores; others read the row.
  assign wval = is_write_r ? stg_rdata : buf_rdata_r;

  // Sequencer: clearing sweep, host commands and reply emission.
  always_comb begin
    st_nxt       = st_r;
    clr_nxt      = clr_r;
    hcnt_nxt     = hcnt_r;
    wcnt_nxt     = wcnt_r;
    rsum_nxt     = rsum_r;
    is_write_nxt = is_write_r;
    last_row_nxt = last_row_r;
    mem_we       = 1'b0;
    mem_waddr    = h_idx;
    mem_wdata    = in_value;
    mem_re       = 1'b0;
    mem_raddr    = h_idx;
    ov_nxt       = ov_r && !out_tready;
    okind_nxt    = okind_r;
    ofirst_nxt   = ofirst_r;
    oval_nxt     = oval_r;
    olast_nxt    = olast_r;
    oent_nxt     = oent_r;
    unique case (st_r)
      csbs_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == AW'(DEPTH - 1)) begin
          st_nxt = csbs_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      csbs_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            csbs_pkg::CMD_BUS: begin
              if (fin.hit) begin
                is_write_nxt = fin.is_write;
                last_row_nxt = p_row;
                hcnt_nxt     = csbs_pkg::HT_ID;
                st_nxt       = csbs_pkg::S_HDR;
              end
            end
            csbs_pkg::CMD_HWR: begin
              mem_we = 1'b1;
            end
            csbs_pkg::CMD_HRD: begin
              mem_re = 1'b1;
              st_nxt = csbs_pkg::S_HRD;
            end
            default: ;
          endcase
        end
      end
      csbs_pkg::S_HRD: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = csbs_pkg::KIND_HOST;
          ofirst_nxt = 1'b0;
          oval_nxt   = buf_rdata_r;
          olast_nxt  = 1'b1;
          oent_nxt   = 4'(last_row_r);
          st_nxt     = csbs_pkg::S_IDLE;
        end
      end
      csbs_pkg::S_HDR: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = csbs_pkg::KIND_REPLY;
          ofirst_nxt = (hcnt_r == csbs_pkg::HT_ID);
          oval_nxt   = hval;
          olast_nxt  = 1'b0;
          oent_nxt   = 4'(last_row_r);
          rsum_nxt   = (hcnt_r == csbs_pkg::HT_ID) ? hval : rsum_r + hval;
          hcnt_nxt   = hcnt_r + 2'd1;
          if (hcnt_r == csbs_pkg::HT_ROW) begin
            wcnt_nxt = '0;
            st_nxt   = csbs_pkg::S_WRD;
          end
        end
      end
      csbs_pkg::S_WRD: begin
        // Staged word read is always running; fetch the buffer word too.
        mem_re    = 1'b1;
        mem_raddr = r_idx;
        st_nxt    = csbs_pkg::S_WDAT;
      end
      csbs_pkg::S_WDAT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = csbs_pkg::KIND_REPLY;
          ofirst_nxt = 1'b0;
          oval_nxt   = wval;
          olast_nxt  = 1'b0;
          oent_nxt   = 4'(last_row_r);
          rsum_nxt   = rsum_r + wval;
          mem_we     = is_write_r;
          mem_waddr  = r_idx;
          mem_wdata  = wval;
          wcnt_nxt   = wcnt_r + LW'(1);
          st_nxt     = (wcnt_nxt == p_len) ? csbs_pkg::S_SUM : csbs_pkg::S_WRD;
        end
      end
      csbs_pkg::S_SUM: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = csbs_pkg::KIND_REPLY;
          ofirst_nxt = 1'b0;
          oval_nxt   = rsum_r;
          olast_nxt  = 1'b1;
          oent_nxt   = 4'(last_row_r);
          st_nxt     = csbs_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = csbs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= csbs_pkg::S_CLEAR;
      clr_r      <= '0;
      hcnt_r     <= '0;
      wcnt_r     <= '0;
      is_write_r <= 1'b0;
      last_row_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clr_r      <= clr_nxt;
      hcnt_r     <= hcnt_nxt;
      wcnt_r     <= wcnt_nxt;
      is_write_r <= is_write_nxt;
      last_row_r <= last_row_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rsum_r   <= rsum_nxt;
    okind_r  <= okind_nxt;
    ofirst_r <= ofirst_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
    oent_r   <= oent_nxt;
  end

  // Buffer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      buf_rdata_r <= buf_mem[mem_raddr];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'd0, oent_r, oval_r, ofirst_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  // The write and read ports never touch the same word in one cycle.
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("buffer read and write collide on one word");

  // Loading the sum token ends the reply with a last-marked result.
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == csbs_pkg::S_SUM && slot_free) |=> (out_tvalid && out_tlast))
    else $error("reply sum not marked last");

  // The first header token is flagged as the start of a reply.
  a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == csbs_pkg::S_HDR && hcnt_r == csbs_pkg::HT_ID && slot_free)
      |=> (out_tvalid && out_tdata[0] && !out_tuser))
    else $error("reply start token not flagged");

  // No input transfer is taken while a reply is in progress.
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == csbs_pkg::S_WRD || st_r == csbs_pkg::S_WDAT) |-> !in_acc)
    else $error("input taken during reply word loop");

endmodule

// ----- bench/checksummed_register_bus_slave_top_tb.sv -----
// Self-checking bench for checksummed_register_bus_slave_top: directed table, then random frames.
// A behavioral predictor of the slave checks every output transfer.
// Depends on csbs_pkg and the RTL of the slave.
`timescale 1ns / 100ps

module checksummed_register_bus_slave_top_tb;

  localparam int ENTRIES = 16;
  localparam int WORDS   = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_ID     = 2'd0;
  localparam logic [1:0] REG_WRITE_CODE  = 2'd1;
  localparam logic [1:0] REG_RETURN_CODE = 2'd2;

  // Short names of the command codes for the directed table.
  localparam csbs_pkg::cmd_t C_BUS  = csbs_pkg::CMD_BUS;
  localparam csbs_pkg::cmd_t C_HWR  = csbs_pkg::CMD_HWR;
  localparam csbs_pkg::cmd_t C_HRD  = csbs_pkg::CMD_HRD;
  localparam csbs_pkg::cmd_t C_NONE = csbs_pkg::CMD_NONE;

  localparam int RAND_ITEMS  = 330;
  localparam int PHASES      = 5;
  localparam int DRAIN       = 64;
  localparam int CYCLE_LIMIT = 400000;

  // One output transfer as the slave should produce it.
  typedef struct packed {
    logic        kind;
    logic        first;
    logic [31:0] val;
    logic        last;
    logic [3:0]  row;
  } slave_result_t;

  // One row of the directed table; typed rows carry their host read result.
  typedef struct packed {
    csbs_pkg::cmd_t cmd;
    logic        start;
    logic [31:0] value;
    logic [3:0]  entry;
    logic [3:0]  word;
    logic        typed;
    logic [31:0] exp_value;
    logic [3:0]  exp_row;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  // Predictor state.
  logic [31:0] store [0:ENTRIES*WORDS-1];
  logic [31:0] staged [0:WORDS-1];
  csbs_pkg::phase_t fr_phase;
  logic [31:0] fr_id;
  logic [31:0] fr_type;
  logic [31:0] fr_addr;
  logic [31:0] fr_sum;
  int unsigned fr_len;
  int unsigned fr_seen;
  logic [3:0]  cur_row;
  logic [7:0]  node_id_q;
  logic [7:0]  write_code_q;
  logic [7:0]  return_code_q;

  slave_result_t pending_results[$];
  dir_row_t      dir_tab[$];
  int unsigned   fails = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_cnt = 0;
  bit            no_idle = 1'b0;

  checksummed_register_bus_slave_top #(
    .ENTRIES(ENTRIES),
    .WORDS  (WORDS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Signed clamp of a 32-bit token into lo..hi.
  function automatic logic [31:0] clamp_s(input logic [31:0] v, input int lo, input int hi);
    int s;
    s = $signed(v);
    if (s < lo) return 32'(lo);
    if (s > hi) return 32'(hi);
    return v;
  endfunction

  task automatic push_result(input logic kind, input logic first, input logic [31:0] val,
                             input logic last);
    slave_result_t r;
    r.kind  = kind;
    r.first = first;
    r.val   = val;
    r.last  = last;
    r.row   = cur_row;
    pending_results.push_back(r);
  endtask

  // Predict the results of one accepted input transfer and update the state copy.
  task automatic predict_slave(input csbs_pkg::cmd_t cmd, input logic start,
                               input logic [31:0] v, input logic [3:0] e,
                               input logic [3:0] w);
    int unsigned idx;
    int unsigned base;
    int unsigned i;
    logic [31:0] rsum;
    // With 16 rows and 16 words the 4-bit host indices never need clamping.
    idx = e * WORDS + w;
    case (cmd)
      csbs_pkg::CMD_HWR: store[idx] = v;
      csbs_pkg::CMD_HRD: push_result(csbs_pkg::KIND_HOST, 1'b0, store[idx], 1'b1);
      csbs_pkg::CMD_BUS: begin
        if (start) begin
          // A start token always opens a new frame.
          fr_id    = v;
          fr_sum   = v;
          fr_phase = csbs_pkg::PH_TYPE;
        end else begin
          case (fr_phase)
            csbs_pkg::PH_TYPE: begin
              fr_type  = v;
              fr_sum   = fr_sum + v;
              fr_phase = csbs_pkg::PH_LEN;
            end
            csbs_pkg::PH_LEN: begin
              fr_len   = clamp_s(v, 1, WORDS);
              fr_sum   = fr_sum + 32'(fr_len);
              fr_phase = csbs_pkg::PH_ADDR;
            end
            csbs_pkg::PH_ADDR: begin
              fr_addr  = v;
              fr_sum   = fr_sum + v;
              fr_seen  = 0;
              fr_phase = csbs_pkg::PH_DATA;
            end
            csbs_pkg::PH_DATA: begin
              if (fr_seen < WORDS) staged[fr_seen] = v;
              fr_sum  = fr_sum + v;
              fr_seen = fr_seen + 1;
              if (fr_seen >= fr_len) fr_phase = csbs_pkg::PH_SUM;
            end
            csbs_pkg::PH_SUM: begin
              fr_phase = csbs_pkg::PH_IDLE;
              // Only a frame for this node with a good sum is answered.
              if (fr_id == {24'd0, node_id_q} && fr_sum == v) begin
                cur_row = 4'(clamp_s(fr_addr, 0, ENTRIES - 1));
                base    = cur_row * WORDS;
                if (fr_type == {24'd0, write_code_q}) begin
                  for (i = 0; i < fr_len; i++) store[base + i] = staged[i];
                end
                rsum = fr_id + {24'd0, return_code_q} + 32'(fr_len) + {28'd0, cur_row};
                push_result(csbs_pkg::KIND_REPLY, 1'b1, fr_id, 1'b0);
                push_result(csbs_pkg::KIND_REPLY, 1'b0, {24'd0, return_code_q}, 1'b0);
                push_result(csbs_pkg::KIND_REPLY, 1'b0, 32'(fr_len), 1'b0);
                push_result(csbs_pkg::KIND_REPLY, 1'b0, {28'd0, cur_row}, 1'b0);
                for (i = 0; i < fr_len; i++) begin
                  rsum = rsum + store[base + i];
                  push_result(csbs_pkg::KIND_REPLY, 1'b0, store[base + i], 1'b0);
                end
                push_result(csbs_pkg::KIND_REPLY, 1'b0, rsum, 1'b1);
              end
            end
            // Tokens outside a frame are ignored.
            default: fr_phase = csbs_pkg::PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  // Drive one input transfer after a random gap and predict it once it is taken.
  task automatic send_item(input csbs_pkg::cmd_t cmd, input logic start,
                           input logic [31:0] v, input logic [3:0] e,
                           input logic [3:0] w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, w, e, v, start};
    do @(posedge clk); while (!in_tready);
    predict_slave(cmd, start, v, e, w);
    items_sent = items_sent + 1;
  endtask

  // The write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_NODE_ID:     node_id_q = val;
      REG_WRITE_CODE:  write_code_q = val;
      REG_RETURN_CODE: return_code_q = val;
      default: ;
    endcase
  endtask

  // Let every expected result arrive, then give the block time to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Host access or noise: reads, writes, unused commands and stray tokens.
  task automatic send_host_op();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        send_item(csbs_pkg::CMD_HRD, 1'($urandom), $urandom, 4'($urandom), 4'($urandom));
      6, 7, 8:
        send_item(csbs_pkg::CMD_HWR, 1'($urandom), $urandom, 4'($urandom), 4'($urandom));
      default:
        if ($urandom_range(0, 1) == 0)
          send_item(csbs_pkg::CMD_NONE, 1'($urandom), $urandom, 4'($urandom), 4'($urandom));
        else
          send_item(csbs_pkg::CMD_BUS, 1'b0, $urandom, 4'($urandom), 4'($urandom));
    endcase
  endtask

  // A frame with random content, mostly well formed; a truncated one is abandoned.
  task automatic send_frame(input bit truncate);
    logic [31:0] toks[$];
    logic [31:0] id;
    logic [31:0] ftype;
    logic [31:0] len_tok;
    logic [31:0] addr;
    logic [31:0] sum;
    logic [31:0] d;
    int unsigned n_words;
    int unsigned n_send;
    int unsigned i;
    case ($urandom_range(0, 9))
      0:       id = $urandom;
      1:       id = {24'($urandom_range(1, 24'hFFFFFF)), node_id_q};
      default: id = {24'd0, node_id_q};
    endcase
    case ($urandom_range(0, 9))
      7:       ftype = {24'($urandom_range(1, 24'hFFFFFF)), write_code_q};
      8, 9:    ftype = $urandom;
      default: ftype = {24'd0, write_code_q};
    endcase
    case ($urandom_range(0, 9))
      6: begin
        n_words = 1;
        len_tok = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
      end
      7: begin
        n_words = WORDS;
        len_tok = WORDS;
      end
      8: begin
        n_words = WORDS;
        len_tok = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : $urandom_range(WORDS + 1, 1000);
      end
      9: begin
        n_words = $urandom_range(5, WORDS - 1);
        len_tok = n_words;
      end
      default: begin
        n_words = $urandom_range(1, 4);
        len_tok = n_words;
      end
    endcase
    case ($urandom_range(0, 9))
      8:       addr = $urandom;
      9:       addr = $urandom | 32'h8000_0000;
      default: addr = $urandom_range(0, ENTRIES - 1);
    endcase
    sum = id + ftype + 32'(n_words) + addr;
    toks.push_back(id);
    toks.push_back(ftype);
    toks.push_back(len_tok);
    toks.push_back(addr);
    for (i = 0; i < n_words; i++) begin
      d = $urandom;
      sum = sum + d;
      toks.push_back(d);
    end
    // Now and then a single flipped bit spoils the sum.
    if ($urandom_range(0, 9) == 0) sum = sum ^ (32'd1 << $urandom_range(0, 31));
    toks.push_back(sum);
    n_send = truncate ? $urandom_range(1, toks.size() - 1) : toks.size();
    for (i = 0; i < n_send; i++) begin
      if (i != 0 && $urandom_range(0, 9) == 0) send_host_op();
      send_item(csbs_pkg::CMD_BUS, i == 0, toks[i], 4'($urandom), 4'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fails = fails + 1;
    end
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    slave_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %h", $time,
                 out_tdata[32:1]);
        fails = fails + 1;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("kind", 32'(exp_r.kind), 32'(out_tuser));
        check_field("reply_first", 32'(exp_r.first), 32'(out_tdata[0]));
        check_field("value_res", exp_r.val, out_tdata[32:1]);
        check_field("last", 32'(exp_r.last), 32'(out_tlast));
        check_field("last_entry", 32'(exp_r.row), 32'(out_tdata[36:33]));
      end
    end
  end

  // Receiver: random stall before each output transfer.
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Stimulus: reset, directed table, then random phases with new settings.
  initial begin
    int unsigned k;
    int unsigned ph;
    int unsigned phase_end;
    dir_row_t row;
    slave_result_t typed_r;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= csbs_pkg::CMD_NONE;
    cfg_we    <= 1'b0;
    cfg_index <= REG_NODE_ID;
    cfg_wdata <= '0;

    for (k = 0; k < ENTRIES * WORDS; k++) store[k] = '0;
    for (k = 0; k < WORDS; k++) staged[k] = '0;
    fr_phase      = csbs_pkg::PH_IDLE;
    fr_id         = '0;
    fr_type       = '0;
    fr_addr       = '0;
    fr_sum        = '0;
    fr_len        = 0;
    fr_seen       = 0;
    cur_row       = '0;
    node_id_q     = 8'd0;
    write_code_q  = 8'd1;
    return_code_q = 8'd3;

    // Host access at the corners, ignored items, then two frames with clamps and a restart.
    dir_tab.push_back('{C_HRD, 1'b0, 32'h0000_0000, 4'd0, 4'd0, 1'b1, 32'h0000_0000, 4'd0});
    dir_tab.push_back('{C_HWR, 1'b0, 32'hFFFF_FFFF, 4'd15, 4'd15, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_HRD, 1'b0, 32'h0000_0000, 4'd15, 4'd15, 1'b1, 32'hFFFF_FFFF, 4'd0});
    dir_tab.push_back('{C_HWR, 1'b0, 32'h8000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_HRD, 1'b0, 32'h0000_0000, 4'd0, 4'd0, 1'b1, 32'h8000_0000, 4'd0});
    dir_tab.push_back('{C_NONE, 1'b1, 32'h5A5A_5A5A, 4'd7, 4'd9, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_1234, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    // Write frame: negative length and address clamp to 1 and row 0.
    dir_tab.push_back('{C_BUS, 1'b1, 32'h0000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0001, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h8000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h8000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h7FFF_FFFF, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0001, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    // Frame abandoned by a new start, then a read-type frame to the top row.
    dir_tab.push_back('{C_BUS, 1'b1, 32'h0000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0001, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b1, 32'h0000_0000, 4'd3, 4'd5, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0000, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0002, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h7FFF_FFFF, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_HRD, 1'b0, 32'h0000_0000, 4'd15, 4'd15, 1'b1, 32'hFFFF_FFFF, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0001, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h0000_0002, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_BUS, 1'b0, 32'h8000_0004, 4'd0, 4'd0, 1'b0, 32'h0, 4'd0});
    dir_tab.push_back('{C_HRD, 1'b0, 32'h0000_0000, 4'd0, 4'd0, 1'b1, 32'h7FFF_FFFF, 4'd15});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; typed rows replace the predicted host read result.
    for (k = 0; k < dir_tab.size(); k++) begin
      row = dir_tab[k];
      send_item(row.cmd, row.start, row.value, row.entry, row.word);
      if (row.typed) begin
        typed_r.kind  = csbs_pkg::KIND_HOST;
        typed_r.first = 1'b0;
        typed_r.val   = row.exp_value;
        typed_r.last  = 1'b1;
        typed_r.row   = row.exp_row;
        void'(pending_results.pop_back());
        pending_results.push_back(typed_r);
      end
    end

    // Random phases, each under its own register settings.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_NODE_ID, 8'd255);
          write_reg(REG_WRITE_CODE, 8'd0);
          write_reg(REG_RETURN_CODE, 8'd255);
        end
        1: begin
          write_reg(REG_NODE_ID, 8'd0);
          write_reg(REG_WRITE_CODE, 8'd255);
          write_reg(REG_RETURN_CODE, 8'd0);
        end
        default: begin
          write_reg(REG_NODE_ID, 8'($urandom));
          write_reg(REG_WRITE_CODE, 8'($urandom));
          write_reg(REG_RETURN_CODE, 8'($urandom));
        end
      endcase
      cfg_we <= 1'b0;
      // One phase runs back to back on both sides.
      no_idle   = (ph == 2);
      phase_end = items_sent + RAND_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_frame(1'b0);
          6:                send_frame(1'b1);
          default:          send_host_op();
        endcase
      end
    end

    wait_idle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/csbs_pkg.sv
src/csbs_parser.sv
src/checksummed_register_bus_slave_top.sv
bench/checksummed_register_bus_slave_top_tb.sv
